// ----- hw/rtl/ccfr_pkg.sv -----
// shared constants for the crc-checked frame receiver
package ccfr_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CRC_W  = 16;
    localparam int unsigned POS_W  = 9;
    localparam int unsigned FLD_W  = 4;
    localparam int unsigned CFG_IDX_W = 8;

    // frame kinds as sampled with the start byte
    localparam logic KIND_MESSAGE = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    // result kinds
    localparam logic RESULT_PAYLOAD = 1'b0;
    localparam logic RESULT_SUMMARY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_POLY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SEED = 8'd1;

    localparam logic [CRC_W-1:0] CRC_POLY_RESET = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_SEED_RESET = 16'hFFFF;

    // header lengths including the start byte
    localparam logic [POS_W-1:0] HDR_LEN_MSG = 9'd4;
    localparam logic [POS_W-1:0] HDR_LEN_ACK = 9'd3;

endpackage

// ----- hw/rtl/ccfr_crc_byte.sv -----
// one byte of a bitwise msb-first crc-16, unrolled into xor logic
module ccfr_crc_byte
    import ccfr_pkg::*;
(
    input  logic [CRC_W-1:0]  crc_in,
    input  logic [BYTE_W-1:0] data,
    input  logic [CRC_W-1:0]  poly,
    output logic [CRC_W-1:0]  crc_out
);

    // eight shift steps, feedback from crc msb xor data msb
    always_comb
    begin
        logic [CRC_W-1:0]  crc;
        logic [BYTE_W-1:0] d;
        logic              fb;
        crc = crc_in;
        d   = data;
        for (int k = 0; k < BYTE_W; k++)
        begin
            fb  = crc[CRC_W-1] ^ d[BYTE_W-1];
            crc = {crc[CRC_W-2:0], 1'b0};
            if (fb)
            begin
                crc = crc ^ poly;
            end
            d = {d[BYTE_W-2:0], 1'b0};
        end
        crc_out = crc;
    end

endmodule

// ----- hw/rtl/crc_checked_frame_receiver_core.sv -----
// crc-checked frame receiver top level: byte-wide frame parser with crc-16 check
// results are registered: each input transfer's result lands in the output register
// throughput: one byte per cycle when not stalled; crc byte step is pure xor logic
// an input transfer is taken whenever the output register is empty or being emptied
// reset: awaits a start byte, polynomial 0x1021, seed 0xffff, output register empty
module crc_checked_frame_receiver_core
    import ccfr_pkg::*;
#(
    parameter int unsigned ADDR_BITS = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input byte channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    rx_byte,
    input  logic                 frame_kind,
    // configuration channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CRC_W-1:0]     cfg_data,
    // result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 result_kind,
    output logic [BYTE_W-1:0]    payload_byte,
    output logic                 kind_of_frame,
    output logic [BYTE_W-1:0]    sof_byte,
    output logic [FLD_W-1:0]     src_channel,
    output logic [FLD_W-1:0]     src_address,
    output logic [FLD_W-1:0]     dest_channel,
    output logic [FLD_W-1:0]     dest_address,
    output logic [BYTE_W-1:0]    payload_size,
    output logic [CRC_W-1:0]     received_crc,
    output logic [BYTE_W-1:0]    eof_byte,
    output logic                 crc_error
);

    localparam logic [BYTE_W:0]   ADDR_ONE  = (BYTE_W+1)'(1);
    localparam logic [BYTE_W-1:0] ADDR_MASK = BYTE_W'((ADDR_ONE << ADDR_BITS) - ADDR_ONE);

    // configuration registers
    logic [CRC_W-1:0] poly_reg;
    logic [CRC_W-1:0] seed_reg;

    // frame state
    logic [POS_W-1:0]  pos_reg,  pos_next;
    logic [CRC_W-1:0]  crc_reg,  crc_next;
    logic              kind_reg, kind_next;
    logic [BYTE_W-1:0] sof_reg,  sof_next;
    logic [BYTE_W-1:0] src_reg,  src_next;
    logic [BYTE_W-1:0] dst_reg,  dst_next;
    logic [BYTE_W-1:0] size_reg, size_next;
    logic [CRC_W-1:0]  rxcrc_reg, rxcrc_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic              rkind_reg;
    logic [BYTE_W-1:0] pbyte_reg;
    logic              okind_reg;
    logic [BYTE_W-1:0] osof_reg;
    logic [FLD_W-1:0]  osrc_ch_reg, osrc_ad_reg, odst_ch_reg, odst_ad_reg;
    logic [BYTE_W-1:0] osize_reg;
    logic [CRC_W-1:0]  orxcrc_reg;
    logic [BYTE_W-1:0] oeof_reg;
    logic              oerr_reg;

    logic              in_xfer;
    logic              emit_payload;
    logic              emit_summary;
    logic [POS_W-1:0]  hdr_len;
    logic [POS_W-1:0]  body_end;
    logic [CRC_W-1:0]  crc_base;
    logic [CRC_W-1:0]  crc_stepped;
    logic [BYTE_W-1:0] src_shift, dst_shift, src_masked, dst_masked;

    // handshakes
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg <= CRC_POLY_RESET;
            seed_reg <= CRC_SEED_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_IDX_POLY)
            begin
                poly_reg <= cfg_data;
            end
            if (cfg_index == CFG_IDX_SEED)
            begin
                seed_reg <= cfg_data;
            end
        end
    end

    // crc byte step, seeded at frame start
    assign crc_base = (pos_reg == '0) ? seed_reg : crc_reg;

    ccfr_crc_byte u_crc_byte (
        .crc_in  (crc_base),
        .data    (rx_byte),
        .poly    (poly_reg),
        .crc_out (crc_stepped)
    );

    // frame layout from the latched kind and size
    assign hdr_len  = (kind_reg == KIND_ACK) ? HDR_LEN_ACK : HDR_LEN_MSG;
    assign body_end = (kind_reg == KIND_ACK) ? HDR_LEN_ACK
                                             : HDR_LEN_MSG + POS_W'(size_reg);

    // frame parser next state
    always_comb
    begin
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        kind_next    = kind_reg;
        sof_next     = sof_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        size_next    = size_reg;
        rxcrc_next   = rxcrc_reg;
        emit_payload = 1'b0;
        emit_summary = 1'b0;
        if (in_xfer)
        begin
            priority if (pos_reg == '0)
            begin
                kind_next = frame_kind;
                sof_next  = rx_byte;
                src_next  = '0;
                dst_next  = '0;
                size_next = '0;
                crc_next  = crc_stepped;
                pos_next  = POS_W'(1);
            end
            else if (pos_reg < hdr_len)
            begin
                unique case (pos_reg[1:0])
                    2'd1:    src_next  = rx_byte;
                    2'd2:    dst_next  = rx_byte;
                    2'd3:    size_next = rx_byte;
                    default: sof_next  = rx_byte;
                endcase
                crc_next = crc_stepped;
                pos_next = pos_reg + POS_W'(1);
            end
            else if (pos_reg < body_end)
            begin
                crc_next     = crc_stepped;
                pos_next     = pos_reg + POS_W'(1);
                emit_payload = 1'b1;
            end
            else if (pos_reg == body_end)
            begin
                rxcrc_next = {rx_byte, BYTE_W'(0)};
                pos_next   = pos_reg + POS_W'(1);
            end
            else if (pos_reg == body_end + POS_W'(1))
            begin
                rxcrc_next = {rxcrc_reg[CRC_W-1:BYTE_W], rx_byte};
                pos_next   = pos_reg + POS_W'(1);
            end
            else
            begin
                emit_summary = 1'b1;
                pos_next     = '0;
            end
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            crc_reg   <= CRC_SEED_RESET;
            kind_reg  <= KIND_MESSAGE;
            sof_reg   <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
            size_reg  <= '0;
            rxcrc_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            kind_reg  <= kind_next;
            sof_reg   <= sof_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            size_reg  <= size_next;
            rxcrc_reg <= rxcrc_next;
        end
    end

    // channel and address split of the source and destination bytes
    assign src_shift  = src_reg >> ADDR_BITS;
    assign dst_shift  = dst_reg >> ADDR_BITS;
    assign src_masked = src_reg & ADDR_MASK;
    assign dst_masked = dst_reg & ADDR_MASK;

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (emit_payload || emit_summary)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // output register payload, summary fields zero in a payload result
    always_ff @(posedge clk)
    begin
        if (emit_payload)
        begin
            rkind_reg   <= RESULT_PAYLOAD;
            pbyte_reg   <= rx_byte;
            okind_reg   <= 1'b0;
            osof_reg    <= '0;
            osrc_ch_reg <= '0;
            osrc_ad_reg <= '0;
            odst_ch_reg <= '0;
            odst_ad_reg <= '0;
            osize_reg   <= '0;
            orxcrc_reg  <= '0;
            oeof_reg    <= '0;
            oerr_reg    <= 1'b0;
        end
        else if (emit_summary)
        begin
            rkind_reg   <= RESULT_SUMMARY;
            pbyte_reg   <= '0;
            okind_reg   <= kind_reg;
            osof_reg    <= sof_reg;
            osrc_ch_reg <= src_shift[FLD_W-1:0];
            osrc_ad_reg <= src_masked[FLD_W-1:0];
            odst_ch_reg <= dst_shift[FLD_W-1:0];
            odst_ad_reg <= dst_masked[FLD_W-1:0];
            osize_reg   <= (kind_reg == KIND_ACK) ? BYTE_W'(0) : size_reg;
            orxcrc_reg  <= rxcrc_reg;
            oeof_reg    <= rx_byte;
            oerr_reg    <= (~crc_reg) != rxcrc_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = rkind_reg;
    assign payload_byte  = pbyte_reg;
    assign kind_of_frame = okind_reg;
    assign sof_byte      = osof_reg;
    assign src_channel   = osrc_ch_reg;
    assign src_address   = osrc_ad_reg;
    assign dest_channel  = odst_ch_reg;
    assign dest_address  = odst_ad_reg;
    assign payload_size  = osize_reg;
    assign received_crc  = orxcrc_reg;
    assign eof_byte      = oeof_reg;
    assign crc_error     = oerr_reg;

endmodule
